// File: src/timed_register_write_queue_defines.svh
// assertion macros for the timed register write queue
`ifndef TIMED_REGISTER_WRITE_QUEUE_DEFINES_SVH
`define TIMED_REGISTER_WRITE_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmq check failed");

// next-cycle implication, checked outside reset
`define TMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmq check failed");

`endif

// File: src/tmq_pkg.sv
// shared types, constants and helpers for the timed register write queue
package tmq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int THR_W       = 11;
    localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(250);

    localparam logic [1:0] OP_ENQ_WRITE = 2'd0;
    localparam logic [1:0] OP_ENQ_WAIT  = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;
    localparam logic [1:0] OP_FLUSH     = 2'd3;

    typedef struct packed {
        logic        wait_only;
        logic [4:0]  addr;
        logic [7:0]  data;
        logic [15:0] wait_ticks;
    } t_record;

    localparam int REC_W = $bits(t_record);

    function automatic logic [IDX_W-1:0] tmq_next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// File: src/tmq_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
module tmq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/timed_register_write_queue.sv
// timed register write queue: command ring in ram, tick-driven playback, result register
//
// input channel (i_in_valid / o_in_ready) takes one command beat: enqueue write,
// enqueue wait, tick or flush. output channel (o_out_valid / i_out_ready) gives
// exactly one result beat per command: reject status, optional bus write,
// record count after the command and the nearly-full flag.
// enqueues, flushes and ticks that do not pop give their result in the cycle after accept.
// a tick that pops the head goes through S_POP: first the synchronous ram read of
// the head record, then the player load and the result. one command per cycle is
// accepted while the receiver takes each result; o_in_ready is low in S_POP.
// the result register lets a new command be accepted in the cycle the previous
// result is taken; while the receiver stalls, o_in_ready stays low.
// i_cfg_we writes the start threshold; write it only while idle.
// reset (synchronous, active low) empties the queue, stops the player and sets
// the threshold to 250; ram contents are left as they are and need no clearing.
// a flush empties the queue and drops any record being played.
`include "timed_register_write_queue_defines.svh"

module timed_register_write_queue
    import tmq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [THR_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_opcode,
    input  logic [4:0]             i_reg_addr,
    input  logic [7:0]             i_reg_data,
    input  logic [15:0]            i_wait_ticks,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_status,
    output logic                   o_write_strobe,
    output logic [4:0]             o_bus_addr,
    output logic [7:0]             o_bus_data,
    output logic [CNT_W-1:0]       o_record_count,
    output logic                   o_nearly_full
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic             r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_playing, n_playing;
    logic [15:0]      r_remaining, n_remaining;
    t_record          r_cur, n_cur;
    logic [THR_W-1:0] r_threshold;

    logic             r_out_valid, n_out_valid;
    logic             r_status, n_status;
    logic             r_strobe, n_strobe;
    logic [4:0]       r_baddr, n_baddr;
    logic [7:0]       r_bdata, n_bdata;
    logic [CNT_W-1:0] r_ocount, n_ocount;

    logic             accept;
    logic             queue_full;
    logic             can_pop;
    logic             mem_we;
    logic             mem_re;
    t_record          wr_rec;
    t_record          rd_rec;

    tmq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (wr_rec),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (rd_rec)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign queue_full = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign can_pop    = !r_playing && (CMP_W'(r_count) > CMP_W'(r_threshold));

    always_comb begin
        wr_rec.wait_only  = (i_opcode == OP_ENQ_WAIT);
        wr_rec.addr       = (i_opcode == OP_ENQ_WRITE) ? i_reg_addr : 5'd0;
        wr_rec.data       = (i_opcode == OP_ENQ_WRITE) ? i_reg_data : 8'd0;
        wr_rec.wait_ticks = i_wait_ticks;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_playing   = r_playing;
        n_remaining = r_remaining;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_strobe    = r_strobe;
        n_baddr     = r_baddr;
        n_bdata     = r_bdata;
        n_ocount    = r_ocount;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = 1'b0;
                    n_strobe = 1'b0;
                    n_baddr  = 5'd0;
                    n_bdata  = 8'd0;
                    case (i_opcode)
                        OP_ENQ_WRITE, OP_ENQ_WAIT: begin
                            if (queue_full) begin
                                n_status = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_tail  = tmq_next_idx(r_tail);
                                n_count = r_count + 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_TICK: begin
                            if (can_pop) begin
                                // head record comes back next cycle
                                mem_re  = 1'b1;
                                n_head  = tmq_next_idx(r_head);
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                            end else begin
                                if (r_playing) begin
                                    if (r_remaining == 16'd0) begin
                                        n_strobe  = !r_cur.wait_only;
                                        n_baddr   = r_cur.wait_only ? 5'd0 : r_cur.addr;
                                        n_bdata   = r_cur.wait_only ? 8'd0 : r_cur.data;
                                        n_playing = 1'b0;
                                    end else begin
                                        n_remaining = r_remaining - 1'b1;
                                    end
                                end
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_FLUSH: begin
                            n_head      = '0;
                            n_tail      = '0;
                            n_count     = '0;
                            n_playing   = 1'b0;
                            n_remaining = 16'd0;
                            n_cur       = '0;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_ocount = n_count;
                end
            end
            S_POP: begin
                // zero wait completes in the pop tick itself
                if (rd_rec.wait_ticks == 16'd0) begin
                    n_strobe  = !rd_rec.wait_only;
                    n_baddr   = rd_rec.wait_only ? 5'd0 : rd_rec.addr;
                    n_bdata   = rd_rec.wait_only ? 8'd0 : rd_rec.data;
                    n_playing = 1'b0;
                end else begin
                    n_playing   = 1'b1;
                    n_remaining = rd_rec.wait_ticks - 1'b1;
                end
                n_cur       = rd_rec;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_playing   <= 1'b0;
            r_remaining <= 16'd0;
            r_cur       <= '0;
            r_threshold <= THRESHOLD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_playing   <= n_playing;
            r_remaining <= n_remaining;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_strobe <= n_strobe;
        r_baddr  <= n_baddr;
        r_bdata  <= n_bdata;
        r_ocount <= n_ocount;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_write_strobe = r_strobe;
    assign o_bus_addr     = r_baddr;
    assign o_bus_data     = r_bdata;
    assign o_record_count = r_ocount;
    assign o_nearly_full  = (r_ocount >= CNT_W'(QUEUE_DEPTH - 1));

    `TMQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `TMQ_ASSERT_NOW(a_pop_out_free, i_clk, i_rst_n, r_state == S_POP, !r_out_valid)
    `TMQ_ASSERT_NEXT(a_pop_one_cycle, i_clk, i_rst_n, r_state == S_POP,
        (r_state == S_IDLE) && r_out_valid)
    `TMQ_ASSERT_NOW(a_no_pop_while_playing, i_clk, i_rst_n, r_state == S_POP, !r_playing)

endmodule

// File: tb/timed_register_write_queue_test.sv
// self-checking testbench for the timed register write queue: directed cases, then random traffic
module timed_register_write_queue_test;
    import tmq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic             status;
        logic             write_strobe;
        logic [4:0]       bus_addr;
        logic [7:0]       bus_data;
        logic [CNT_W-1:0] record_count;
        logic             nearly_full;
    } t_bus_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_we     = 1'b0;
    logic [THR_W-1:0] i_cfg_data   = '0;
    logic             i_in_valid   = 1'b0;
    logic [1:0]       i_opcode     = OP_TICK;
    logic [4:0]       i_reg_addr   = '0;
    logic [7:0]       i_reg_data   = '0;
    logic [15:0]      i_wait_ticks = '0;
    logic             i_out_ready  = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_status;
    logic             o_write_strobe;
    logic [4:0]       o_bus_addr;
    logic [7:0]       o_bus_data;
    logic [CNT_W-1:0] o_record_count;
    logic             o_nearly_full;

    // shadow copy of the queue and player
    t_record shadow_records [QUEUE_DEPTH];
    int      shadow_head      = 0;
    int      shadow_tail      = 0;
    int      shadow_count     = 0;
    bit      shadow_playing   = 1'b0;
    int      shadow_remaining = 0;
    t_record shadow_current   = '0;
    int      shadow_threshold = 250;

    t_bus_result awaited_results [$];
    bit          failed      = 1'b0;
    bit          no_idle     = 1'b0;
    int          sink_stall  = 0;
    int          cycle_count = 0;

    timed_register_write_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_reg_addr     (i_reg_addr),
        .i_reg_data     (i_reg_data),
        .i_wait_ticks   (i_wait_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_write_strobe (o_write_strobe),
        .o_bus_addr     (o_bus_addr),
        .o_bus_data     (o_bus_data),
        .o_record_count (o_record_count),
        .o_nearly_full  (o_nearly_full)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, none while no_idle is set
    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_wait();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 16'($urandom_range(0, 3));
        end else if (r < 92) begin
            return 16'($urandom_range(0, 20));
        end
        return 16'($urandom);
    endfunction

    // applies one command to the shadow state and returns the result it should give
    function automatic t_bus_result play_command(logic [1:0] op, logic [4:0] addr,
                                                 logic [7:0] data, logic [15:0] ticks);
        t_bus_result res;
        t_record     rec;
        res = '0;
        case (op)
            OP_ENQ_WRITE, OP_ENQ_WAIT: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    rec.wait_only  = (op == OP_ENQ_WAIT);
                    rec.addr       = (op == OP_ENQ_WAIT) ? 5'd0 : addr;
                    rec.data       = (op == OP_ENQ_WAIT) ? 8'd0 : data;
                    rec.wait_ticks = ticks;
                    shadow_records[shadow_tail] = rec;
                    shadow_tail  = (shadow_tail + 1) % QUEUE_DEPTH;
                    shadow_count = shadow_count + 1;
                end
            end
            OP_TICK: begin
                if (!shadow_playing && shadow_count > shadow_threshold) begin
                    shadow_current   = shadow_records[shadow_head];
                    shadow_head      = (shadow_head + 1) % QUEUE_DEPTH;
                    shadow_count     = shadow_count - 1;
                    shadow_remaining = shadow_current.wait_ticks;
                    shadow_playing   = 1'b1;
                end
                // a record popped now with wait 0 completes in this same tick
                if (shadow_playing) begin
                    if (shadow_remaining == 0) begin
                        if (!shadow_current.wait_only) begin
                            res.write_strobe = 1'b1;
                            res.bus_addr     = shadow_current.addr;
                            res.bus_data     = shadow_current.data;
                        end
                        shadow_playing = 1'b0;
                    end else begin
                        shadow_remaining = shadow_remaining - 1;
                    end
                end
            end
            OP_FLUSH: begin
                shadow_head      = 0;
                shadow_tail      = 0;
                shadow_count     = 0;
                shadow_playing   = 1'b0;
                shadow_remaining = 0;
                shadow_current   = '0;
            end
        endcase
        res.record_count = CNT_W'(shadow_count);
        res.nearly_full  = (shadow_count >= QUEUE_DEPTH - 1);
        return res;
    endfunction

    task automatic send_command(input logic [1:0] op, input logic [4:0] addr,
                                input logic [7:0] data, input logic [15:0] ticks);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_reg_addr   <= addr;
        i_reg_data   <= data;
        i_wait_ticks <= ticks;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        awaited_results.push_back(play_command(op, addr, data, ticks));
    endtask

    // tick and flush carry random values in the fields they ignore
    task automatic send_tick();
        send_command(OP_TICK, 5'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic send_flush();
        send_command(OP_FLUSH, 5'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic send_random_record(input logic [15:0] ticks);
        send_command(($urandom_range(0, 3) == 0) ? OP_ENQ_WAIT : OP_ENQ_WRITE,
                     5'($urandom), 8'($urandom), ticks);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= THR_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_threshold = value;
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            failed = 1'b1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_bus_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                failed = 1'b1;
                $display("%0t: result beat with nothing expected", $time);
            end else begin
                exp_res = awaited_results.pop_front();
                check_field("status", exp_res.status, o_status);
                check_field("write_strobe", exp_res.write_strobe, o_write_strobe);
                check_field("bus_addr", exp_res.bus_addr, o_bus_addr);
                check_field("bus_data", exp_res.bus_data, o_bus_data);
                check_field("record_count", exp_res.record_count, o_record_count);
                check_field("nearly_full", exp_res.nearly_full, o_nearly_full);
            end
        end
    end

    always @(posedge i_clk) begin : sink_pacing
        int g;
        if (sink_stall > 0) begin
            sink_stall  <= sink_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                sink_stall  <= g - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // reset value 250: 250 held records do not start playback, 251 do
    task automatic test_default_threshold();
        send_command(OP_ENQ_WRITE, 5'd31, 8'd255, 16'd0);
        send_command(OP_ENQ_WRITE, 5'd0, 8'd0, 16'hffff);
        send_command(OP_ENQ_WAIT, 5'd31, 8'd255, 16'hffff);
        no_idle = 1'b1;
        repeat (247) send_random_record(pick_wait());
        no_idle = 1'b0;
        send_tick();
        send_random_record(pick_wait());
        send_tick();
        send_tick();
        // the held records stay for the full queue case
    endtask

    task automatic test_full_queue();
        write_threshold(1024);
        no_idle = 1'b1;
        repeat (QUEUE_DEPTH - shadow_count) send_random_record(16'($urandom_range(0, 1)));
        no_idle = 1'b0;
        send_command(OP_ENQ_WRITE, 5'd21, 8'd42, 16'd3);
        send_command(OP_ENQ_WAIT, 5'd0, 8'd0, 16'd3);
        send_tick();
        write_threshold(1023);
        send_tick();
        // if a tick above popped a record, this one lands in the wrapped slot
        send_command(OP_ENQ_WRITE, 5'd17, 8'h5a, 16'd0);
        send_tick();
        send_tick();
        send_flush();
    endtask

    task automatic test_tick_timing();
        write_threshold(0);
        send_tick();
        send_command(OP_ENQ_WRITE, 5'd31, 8'd255, 16'd0);
        send_tick();
        send_command(OP_ENQ_WRITE, 5'd5, 8'ha5, 16'd2);
        repeat (3) send_tick();
        // a wait record ignores the address and data it is given
        send_command(OP_ENQ_WAIT, 5'd31, 8'hff, 16'd1);
        repeat (2) send_tick();
        send_command(OP_ENQ_WAIT, 5'd0, 8'd0, 16'd0);
        send_tick();
        send_command(OP_ENQ_WRITE, 5'd1, 8'd2, 16'd0);
        send_command(OP_ENQ_WRITE, 5'd3, 8'd4, 16'd1);
        repeat (3) send_tick();
    endtask

    task automatic test_flush_in_progress();
        send_command(OP_ENQ_WRITE, 5'd7, 8'd8, 16'hffff);
        send_command(OP_ENQ_WRITE, 5'd10, 8'd11, 16'd0);
        repeat (3) send_tick();
        send_flush();
        send_tick();
        send_command(OP_ENQ_WRITE, 5'd9, 8'd10, 16'd0);
        send_tick();
        send_flush();
    endtask

    task automatic test_random_traffic();
        int thresholds [5] = '{0, 3, 1024, 1, 12};
        int r;
        for (int t = 0; t < 5; t++) begin
            write_threshold(thresholds[t]);
            for (int i = 0; i < 20; i++) begin
                if (i % 10 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 38) begin
                    send_command(OP_ENQ_WRITE, 5'($urandom), 8'($urandom), pick_wait());
                end else if (r < 48) begin
                    send_command(OP_ENQ_WAIT, 5'($urandom), 8'($urandom), pick_wait());
                end else if (r < 97) begin
                    send_tick();
                end else begin
                    send_flush();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_threshold();
        test_full_queue();
        test_tick_timing();
        test_flush_in_progress();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/tmq_pkg.sv
src/tmq_ram.sv
src/timed_register_write_queue.sv
tb/timed_register_write_queue_test.sv
